// ===== rtl/core/csem_pkg.sv =====
// shared constants, codes and the controller-to-datapath command struct
package csem_pkg;

  localparam int TASK_SLOTS = 32;
  localparam int PTR_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int OCC_W      = $clog2(TASK_SLOTS + 1);

  localparam int CFG_W   = 15;
  localparam int TASK_W  = 5;
  localparam int COUNT_W = 16;
  localparam int FAULT_W = 2;

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sd32767;

  typedef enum logic {
    CMD_WAIT = 1'b0,
    CMD_POST = 1'b1
  } op_t;

  typedef enum logic [FAULT_W-1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_FULL  = 2'd1,
    FAULT_MAX   = 2'd2
  } fault_t;

  typedef struct packed {
    logic capture;  // latch the transaction and read the ring head
    logic execute;  // update count and ring, register the result
  } csem_cmd_t;

endpackage

// ===== rtl/core/counting_semaphore_wait_queue.sv =====
// top level: counting semaphore with a fifo queue of waiting tasks
//
// command channel: a transaction (in_cmd, in_task_id) is taken at a rising
// edge with start high and busy low. in_cmd 0 is a wait, 1 is a post.
// result channel: one result per transaction, shown for exactly one cycle
// with out_valid high; the receiver cannot hold it off.
// the transaction is captured at acceptance; the execute state that follows
// updates count and queue and registers the result with out_valid high.
// busy is high in the execute state after acceptance; a new transaction can be
// taken once it falls, also in the cycle the previous result is shown.
// that busy state comes from the registered read of the waiter ring memory: the
// head entry is read at acceptance and used in the execute cycle.
// configuration: cfg_we with cfg_initial_count loads the count and empties
// the queue; write it only while idle.
// reset (rst_n low, synchronous): count 0, queue empty, no result pending;
// queue entries hold no defined value until written.
module counting_semaphore_wait_queue
  import csem_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_cmd,
  input  logic [TASK_W-1:0]         in_task_id,
  input  logic                      cfg_we,
  input  logic [CFG_W-1:0]          cfg_initial_count,
  output logic                      out_valid,
  output logic                      out_caller_blocked,
  output logic                      out_wake_valid,
  output logic [TASK_W-1:0]         out_wake_task,
  output logic [FAULT_W-1:0]        out_fault,
  output logic signed [COUNT_W-1:0] out_count_now
);

  csem_cmd_t cmd;

  csem_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  csem_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_cmd             (in_cmd),
    .in_task_id         (in_task_id),
    .cfg_we             (cfg_we),
    .cfg_initial_count  (cfg_initial_count),
    .out_valid          (out_valid),
    .out_caller_blocked (out_caller_blocked),
    .out_wake_valid     (out_wake_valid),
    .out_wake_task      (out_wake_task),
    .out_fault          (out_fault),
    .out_count_now      (out_count_now)
  );

endmodule

// ===== rtl/core/csem_ctrl.sv =====
// controller state machine: sequences capture and execute of one transaction
module csem_ctrl
  import csem_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output csem_cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.execute = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/csem_dp.sv =====
// datapath: semaphore count, waiter ring memory, pointers and result registers
module csem_dp
  import csem_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  csem_cmd_t                 cmd,
  input  logic                      in_cmd,
  input  logic [TASK_W-1:0]         in_task_id,
  input  logic                      cfg_we,
  input  logic [CFG_W-1:0]          cfg_initial_count,
  output logic                      out_valid,
  output logic                      out_caller_blocked,
  output logic                      out_wake_valid,
  output logic [TASK_W-1:0]         out_wake_task,
  output logic [FAULT_W-1:0]        out_fault,
  output logic signed [COUNT_W-1:0] out_count_now
);

  logic [TASK_W-1:0] ring_mem [TASK_SLOTS];
  logic [TASK_W-1:0] head_data_r;

  logic signed [COUNT_W-1:0] count_r, count_nxt;
  logic [PTR_W-1:0]          head_r, head_nxt;
  logic [PTR_W-1:0]          tail_r, tail_nxt;
  logic [OCC_W-1:0]          occ_r, occ_nxt;

  logic              op_r;
  logic [TASK_W-1:0] task_r;

  logic              blocked;
  logic              wake;
  logic [TASK_W-1:0] wake_task;
  fault_t            fault;
  logic              ring_we;

  logic                      valid_r;
  logic                      blocked_r;
  logic                      wake_r;
  logic [TASK_W-1:0]         wake_task_r;
  logic [FAULT_W-1:0]        fault_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(TASK_SLOTS - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    occ_nxt   = occ_r;
    blocked   = 1'b0;
    wake      = 1'b0;
    wake_task = '0;
    fault     = FAULT_NONE;
    ring_we   = 1'b0;
    if (op_r == CMD_WAIT) begin
      if (count_r <= 0) begin
        // count would go negative: caller joins the queue unless it is full
        if (occ_r >= OCC_W'(TASK_SLOTS)) begin
          fault = FAULT_FULL;
        end else begin
          ring_we   = 1'b1;
          tail_nxt  = ptr_inc(tail_r);
          occ_nxt   = occ_r + OCC_W'(1);
          count_nxt = count_r - 16'sd1;
          blocked   = 1'b1;
        end
      end else begin
        count_nxt = count_r - 16'sd1;
      end
    end else begin
      if (count_r >= COUNT_MAX) begin
        fault = FAULT_MAX;
      end else begin
        count_nxt = count_r + 16'sd1;
        if (count_r < 0 && occ_r != '0) begin
          wake      = 1'b1;
          wake_task = head_data_r;
          head_nxt  = ptr_inc(head_r);
          occ_nxt   = occ_r - OCC_W'(1);
        end
      end
    end
  end

  // ring memory: read of the head is registered at capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      head_data_r <= ring_mem[head_r];
    end
    if (cmd.execute && ring_we) begin
      ring_mem[tail_r] <= task_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_cmd;
      task_r <= in_task_id;
    end
    if (cmd.execute) begin
      blocked_r   <= blocked;
      wake_r      <= wake;
      wake_task_r <= wake_task;
      fault_r     <= fault;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      occ_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.execute;
      if (cfg_we) begin
        count_r <= COUNT_W'({1'b0, cfg_initial_count});
        head_r  <= '0;
        tail_r  <= '0;
        occ_r   <= '0;
      end else if (cmd.execute) begin
        count_r <= count_nxt;
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        occ_r   <= occ_nxt;
      end
    end
  end

  assign out_valid          = valid_r;
  assign out_caller_blocked = blocked_r;
  assign out_wake_valid     = wake_r;
  assign out_wake_task      = wake_task_r;
  assign out_fault          = fault_r;
  assign out_count_now      = count_r;

endmodule

// ===== tb/sv/counting_semaphore_wait_queue_tb.sv =====
// self-checking testbench for the counting semaphore with its fifo of waiting tasks
module counting_semaphore_wait_queue_tb
  import csem_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic                      blocked;
    logic                      woke;
    logic [TASK_W-1:0]         woken_task;
    fault_t                    fault;
    logic signed [COUNT_W-1:0] level;
  } sem_result_t;

  typedef struct packed {
    logic              is_cfg;
    logic [CFG_W-1:0]  cfg_val;
    op_t               op;
    logic [TASK_W-1:0] tid;
    logic              typed;
    sem_result_t       want;
  } stim_row_t;

  typedef enum int {PH_EVEN, PH_DOWN, PH_UP, PH_FILL} phase_kind_t;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic                      in_cmd;
  logic [TASK_W-1:0]         in_task_id;
  logic                      cfg_we;
  logic [CFG_W-1:0]          cfg_initial_count;
  logic                      out_valid;
  logic                      out_caller_blocked;
  logic                      out_wake_valid;
  logic [TASK_W-1:0]         out_wake_task;
  logic [FAULT_W-1:0]        out_fault;
  logic signed [COUNT_W-1:0] out_count_now;

  // predictor state: semaphore count and ring of waiting tasks
  int                level = 0;
  logic [TASK_W-1:0] waiters [TASK_SLOTS];
  int                rd_ptr = 0;
  int                wr_ptr = 0;
  int                waiting = 0;

  sem_result_t results_due [$];
  sem_result_t want;

  int n_errors = 0;
  int n_sent = 0;
  int n_loads = 0;
  int n_blocked = 0;
  int n_woken = 0;
  int n_full = 0;
  int n_at_max = 0;
  int cycle_count = 0;
  int burst_left = 0;

  counting_semaphore_wait_queue dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_cmd             (in_cmd),
    .in_task_id         (in_task_id),
    .cfg_we             (cfg_we),
    .cfg_initial_count  (cfg_initial_count),
    .out_valid          (out_valid),
    .out_caller_blocked (out_caller_blocked),
    .out_wake_valid     (out_wake_valid),
    .out_wake_task      (out_wake_task),
    .out_fault          (out_fault),
    .out_count_now      (out_count_now)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               results_due.size());
      $display("counting_semaphore_wait_queue regression: fail");
      $finish;
    end
  end

  function automatic sem_result_t next_sem_result(op_t op, logic [TASK_W-1:0] tid);
    sem_result_t r;
    r = '0;
    r.fault = FAULT_NONE;
    if (op == CMD_WAIT) begin
      if (level > 0) begin
        level--;
      end else if (waiting >= TASK_SLOTS) begin
        r.fault = FAULT_FULL;
      end else begin
        waiters[wr_ptr] = tid;
        wr_ptr = (wr_ptr + 1) % TASK_SLOTS;
        waiting++;
        level--;
        r.blocked = 1'b1;
      end
    end else if (level >= int'(COUNT_MAX)) begin
      r.fault = FAULT_MAX;
    end else begin
      level++;
      if (level <= 0 && waiting > 0) begin
        r.woke = 1'b1;
        r.woken_task = waiters[rd_ptr];
        rd_ptr = (rd_ptr + 1) % TASK_SLOTS;
        waiting--;
      end
    end
    r.level = level[COUNT_W-1:0];
    return r;
  endfunction

  function automatic stim_row_t row_op(op_t op, logic [TASK_W-1:0] tid);
    stim_row_t s;
    s = '0;
    s.op = op;
    s.tid = tid;
    return s;
  endfunction

  function automatic stim_row_t row_chk(op_t op, logic [TASK_W-1:0] tid, logic blk,
                                        logic wv, logic [TASK_W-1:0] wt, fault_t flt,
                                        int lvl);
    stim_row_t s;
    s = row_op(op, tid);
    s.typed = 1'b1;
    s.want.blocked = blk;
    s.want.woke = wv;
    s.want.woken_task = wt;
    s.want.fault = flt;
    s.want.level = lvl[COUNT_W-1:0];
    return s;
  endfunction

  function automatic stim_row_t row_cfg(logic [CFG_W-1:0] v);
    stim_row_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.cfg_val = v;
    return s;
  endfunction

  task automatic report_mismatch(string what, int got, int exp_v);
    n_errors++;
    if (n_errors <= MAX_PRINTED)
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
               exp_v);
  endtask

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (results_due.size() == 0) begin
        report_mismatch("result with no transaction outstanding", 1, 0);
      end else begin
        want = results_due.pop_front();
        if (out_caller_blocked !== want.blocked)
          report_mismatch("caller_blocked", int'(out_caller_blocked), int'(want.blocked));
        if (out_wake_valid !== want.woke)
          report_mismatch("wake_valid", int'(out_wake_valid), int'(want.woke));
        if (out_wake_task !== want.woken_task)
          report_mismatch("wake_task", int'(out_wake_task), int'(want.woken_task));
        if (out_fault !== want.fault)
          report_mismatch("fault", int'(out_fault), int'(want.fault));
        if (out_count_now !== want.level)
          report_mismatch("count_now", int'(out_count_now), int'(want.level));
      end
    end
  end

  // hold start low until every outstanding result has come back
  task automatic settle();
    start <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
  endtask

  task automatic load_count(logic [CFG_W-1:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_initial_count <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    level = int'(v);
    rd_ptr = 0;
    wr_ptr = 0;
    waiting = 0;
    n_loads++;
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_op(op_t op, logic [TASK_W-1:0] tid, logic typed,
                         sem_result_t typed_want);
    sem_result_t predicted;
    start <= 1'b1;
    in_cmd <= op;
    in_task_id <= tid;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = next_sem_result(op, tid);
    results_due.push_back(typed ? typed_want : predicted);
    n_sent++;
    if (predicted.blocked) n_blocked++;
    if (predicted.woke) n_woken++;
    if (predicted.fault == FAULT_FULL) n_full++;
    if (predicted.fault == FAULT_MAX) n_at_max++;
    @(negedge clk);
  endtask

  initial begin
    stim_row_t   dir_tab [$];
    phase_kind_t phase_kind;
    logic        steady;
    logic [CFG_W-1:0] init_val;
    int          n_ops;
    int          fill_waits;
    int          gap;
    op_t         op;

    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = CMD_WAIT;
    in_task_id = '0;
    cfg_we = 1'b0;
    cfg_initial_count = '0;

    // blocking waits and wakes from reset, count at its maximum, queue cleared by a load
    dir_tab.push_back(row_chk(CMD_WAIT, 5'd0, 1'b1, 1'b0, 5'd0, FAULT_NONE, -1));
    dir_tab.push_back(row_chk(CMD_WAIT, 5'd31, 1'b1, 1'b0, 5'd0, FAULT_NONE, -2));
    dir_tab.push_back(row_chk(CMD_POST, 5'd5, 1'b0, 1'b1, 5'd0, FAULT_NONE, -1));
    dir_tab.push_back(row_chk(CMD_POST, 5'd0, 1'b0, 1'b1, 5'd31, FAULT_NONE, 0));
    dir_tab.push_back(row_chk(CMD_POST, 5'd17, 1'b0, 1'b0, 5'd0, FAULT_NONE, 1));
    dir_tab.push_back(row_chk(CMD_WAIT, 5'd9, 1'b0, 1'b0, 5'd0, FAULT_NONE, 0));
    dir_tab.push_back(row_cfg(15'd32767));
    dir_tab.push_back(row_chk(CMD_POST, 5'd1, 1'b0, 1'b0, 5'd0, FAULT_MAX, 32767));
    dir_tab.push_back(row_chk(CMD_WAIT, 5'd31, 1'b0, 1'b0, 5'd0, FAULT_NONE, 32766));
    dir_tab.push_back(row_chk(CMD_POST, 5'd2, 1'b0, 1'b0, 5'd0, FAULT_NONE, 32767));
    dir_tab.push_back(row_chk(CMD_POST, 5'd31, 1'b0, 1'b0, 5'd0, FAULT_MAX, 32767));
    dir_tab.push_back(row_chk(CMD_WAIT, 5'd0, 1'b0, 1'b0, 5'd0, FAULT_NONE, 32766));
    dir_tab.push_back(row_cfg(15'd1));
    dir_tab.push_back(row_chk(CMD_WAIT, 5'd3, 1'b0, 1'b0, 5'd0, FAULT_NONE, 0));
    dir_tab.push_back(row_chk(CMD_WAIT, 5'd21, 1'b1, 1'b0, 5'd0, FAULT_NONE, -1));
    dir_tab.push_back(row_op(CMD_WAIT, 5'd10));
    dir_tab.push_back(row_cfg(15'd0));
    dir_tab.push_back(row_chk(CMD_POST, 5'd10, 1'b0, 1'b0, 5'd0, FAULT_NONE, 1));
    dir_tab.push_back(row_op(CMD_WAIT, 5'd12));
    dir_tab.push_back(row_op(CMD_WAIT, 5'd30));
    dir_tab.push_back(row_cfg(15'd16384));
    dir_tab.push_back(row_op(CMD_POST, 5'd7));
    dir_tab.push_back(row_op(CMD_WAIT, 5'd25));
    dir_tab.push_back(row_cfg(15'd32766));
    dir_tab.push_back(row_op(CMD_POST, 5'd4));
    dir_tab.push_back(row_op(CMD_POST, 5'd4));
    dir_tab.push_back(row_op(CMD_WAIT, 5'd1));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg)
        load_count(dir_tab[i].cfg_val);
      else
        send_op(dir_tab[i].op, dir_tab[i].tid, dir_tab[i].typed, dir_tab[i].want);
    end

    // random phases; the fill phase runs the queue past full and then drains it
    for (int ph = 0; ph < 20; ph++) begin
      phase_kind = (ph < 4) ? phase_kind_t'(ph) : phase_kind_t'($urandom_range(0, 3));
      steady = ($urandom_range(0, 3) == 0);
      case (phase_kind)
        PH_FILL: begin
          init_val = CFG_W'($urandom_range(0, 4));
        end
        PH_DOWN: begin
          init_val = ($urandom_range(0, 1) != 0) ? CFG_W'($urandom_range(0, 24))
                                                 : CFG_W'($urandom_range(0, 32767));
        end
        PH_UP: begin
          init_val = ($urandom_range(0, 1) != 0) ? CFG_W'(32767 - $urandom_range(0, 30))
                                                 : CFG_W'($urandom_range(0, 32767));
        end
        default: begin
          case ($urandom_range(0, 3))
            0: init_val = '0;
            1: init_val = '1;
            default: init_val = CFG_W'($urandom_range(0, 32767));
          endcase
        end
      endcase
      load_count(init_val);
      n_ops = (phase_kind == PH_FILL) ? 2 * (int'(init_val) + 36) : 60;
      fill_waits = int'(init_val) + TASK_SLOTS + $urandom_range(1, 4);
      for (int k = 0; k < n_ops; k++) begin
        if (!steady) begin
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = $urandom_range(0, 5);
            if (gap != 0) begin
              start <= 1'b0;
              repeat (gap) @(negedge clk);
            end
          end
          burst_left--;
        end
        if (k == n_ops / 2 && (ph == 0 || $urandom_range(0, 2) == 0))
          settle();
        case (phase_kind)
          PH_FILL: op = (k < fill_waits) ? CMD_WAIT : CMD_POST;
          PH_DOWN: op = ($urandom_range(0, 4) != 0) ? CMD_WAIT : CMD_POST;
          PH_UP:   op = ($urandom_range(0, 4) != 0) ? CMD_POST : CMD_WAIT;
          default: op = ($urandom_range(0, 1) != 0) ? CMD_POST : CMD_WAIT;
        endcase
        send_op(op, TASK_W'($urandom_range(0, 31)), 1'b0, '0);
      end
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("ran %0d transactions across %0d count loads: %0d callers blocked, %0d woken",
             n_sent, n_loads, n_blocked, n_woken);
    $display("faults exercised: %0d queue full, %0d count at max; %0d mismatches",
             n_full, n_at_max, n_errors);
    if (n_errors == 0)
      $display("counting_semaphore_wait_queue regression: pass");
    else
      $display("counting_semaphore_wait_queue regression: fail");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/csem_pkg.sv
rtl/core/csem_ctrl.sv
rtl/core/csem_dp.sv
rtl/core/counting_semaphore_wait_queue.sv
tb/sv/counting_semaphore_wait_queue_tb.sv
